// File: src/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg: shared types and constants for the latency histogram
// Holds action codes, register indexes and the controller/datapath command
// and status structs.
// ----------------------------------------------------------------------------
package lhp_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REPORT = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [IDX_W-1:0] REG_LOW_NUM  = 2'd0;
    localparam logic [IDX_W-1:0] REG_LOW_DEN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HIGH_NUM = 2'd2;
    localparam logic [IDX_W-1:0] REG_HIGH_DEN = 2'd3;

    typedef struct packed {
        logic add_first;   // read bucket, update min/max/sum/count
        logic add_write;   // write incremented bucket
        logic clr_start;   // reset scalars and start clear sweep
        logic rep_start;   // latch targets, start divider
        logic div_step;    // one divider step (both targets and the mean)
        logic walk_start;  // reset walk pointer
        logic walk_step;   // accumulate one bucket
        logic out_load;    // load result register
    } lhp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic walk_done;
    } lhp_sts_t;

endpackage

// File: src/latency_histogram_percentile.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentile: log-linear latency histogram with percentiles
// Input channel in_valid/in_stall carries action and sample; output channel
// out_valid/out_stall carries one result per report transaction.
// Add: read-modify-write of the bucket memory.
// Clear: the bucket memory is swept, one memory entry zeroed per cycle.
// Report: after the accept, bit-serial division for the two percentile
// targets and the mean, then a walk over the bucket memory one entry per
// cycle, then the result is loaded once the output register is free.
// Action 3 is accepted and dropped.
// After reset the block runs a clearing pass over the bucket memory with
// in_stall high; config writes are taken meanwhile.
// A result waits in the output register while out_stall is high; the next
// add or clear is accepted meanwhile, and a further report holds there.
// ----------------------------------------------------------------------------
module latency_histogram_percentile #(
    parameter int unsigned NUM_BUCKETS = 168
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] low_pct_edge,
    output logic [31:0] high_pct_edge,
    output logic [31:0] min_seen,
    output logic [31:0] max_seen,
    output logic [31:0] mean_seen,
    output logic [31:0] sample_count,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lhp_pkg::*;

    lhp_cmd_t cmd;
    lhp_sts_t sts;
    logic [15:0] low_num_reg, low_den_reg, high_num_reg, high_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_num_reg  <= 16'd1;
            low_den_reg  <= 16'd2;
            high_num_reg <= 16'd99;
            high_den_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_NUM:  low_num_reg  <= cfg_data;
                REG_LOW_DEN:  low_den_reg  <= cfg_data;
                REG_HIGH_NUM: high_num_reg <= cfg_data;
                REG_HIGH_DEN: high_den_reg <= cfg_data;
                default:      low_num_reg  <= low_num_reg;
            endcase
        end
    end

    lhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    lhp_datapath #(.NUM_BUCKETS(NUM_BUCKETS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .sample        (sample),
        .low_num       (low_num_reg),
        .low_den       (low_den_reg),
        .high_num      (high_num_reg),
        .high_den      (high_den_reg),
        .low_pct_edge  (low_pct_edge),
        .high_pct_edge (high_pct_edge),
        .min_seen      (min_seen),
        .max_seen      (max_seen),
        .mean_seen     (mean_seen),
        .sample_count  (sample_count)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result shown without a load");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample_count)
            && $stable(low_pct_edge) && $stable(high_pct_edge)))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !sts.clr_done |-> in_stall)
        else $error("input taken during clearing pass");
endmodule

// File: src/lhp_divider.sv
// ----------------------------------------------------------------------------
// lhp_divider: restoring divider, one quotient bit per step
// Divides a 64-bit dividend by a 32-bit divisor; quotient holds 64 bits.
// ----------------------------------------------------------------------------
module lhp_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        step,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);
    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        shifted  = {r_reg[31:0], q_reg[63]};
        trial    = shifted - {1'b0, d_reg};
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        if (step && cnt_reg != 7'd0)
        begin
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 7'd0;
        else if (start)
            cnt_reg <= 7'd64;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 33'd0;
            d_reg <= divisor;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient = q_reg;
    assign done     = (cnt_reg == 7'd0);
endmodule

// File: src/lhp_datapath.sv
// ----------------------------------------------------------------------------
// lhp_datapath: histogram memory, running statistics and report arithmetic
// Bucket counts live in a memory swept clear after reset and on clear.
// ----------------------------------------------------------------------------
module lhp_datapath #(
    parameter int unsigned NUM_BUCKETS = 168
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lhp_pkg::lhp_cmd_t     cmd,
    output lhp_pkg::lhp_sts_t     sts,
    input  logic [31:0]           sample,
    input  logic [15:0]           low_num,
    input  logic [15:0]           low_den,
    input  logic [15:0]           high_num,
    input  logic [15:0]           high_den,
    output logic [31:0]           low_pct_edge,
    output logic [31:0]           high_pct_edge,
    output logic [31:0]           min_seen,
    output logic [31:0]           max_seen,
    output logic [31:0]           mean_seen,
    output logic [31:0]           sample_count
);
    import lhp_pkg::*;

    localparam int unsigned BW = $clog2(NUM_BUCKETS);
    localparam logic [BW-1:0] LAST = BW'(NUM_BUCKETS - 1);

    logic [31:0] mem [NUM_BUCKETS];
    logic [31:0] rd_reg;
    logic [BW-1:0] widx_reg;
    logic [BW-1:0] ptr_reg;
    logic [BW-1:0] wk_reg;
    logic [BW-1:0] sidx_reg;
    logic        clr_busy_reg;
    logic        walk_busy_reg;
    logic        rd_valid_reg;
    logic        low_hit_reg, high_hit_reg;

    logic [31:0] min_reg, max_reg, cnt_reg;
    logic [63:0] sum_reg;
    logic [63:0] low_seen_reg, high_seen_reg;
    logic [31:0] low_edge_reg, high_edge_reg;

    logic [31:0] out_low_reg, out_high_reg, out_min_reg, out_max_reg;
    logic [31:0] out_mean_reg, out_cnt_reg;

    logic [47:0] low_prod_reg, high_prod_reg;
    logic [15:0] lden_reg, hden_reg;
    logic [63:0] low_q, high_q, mean_q;
    logic        low_done, high_done, mean_done;
    logic [63:0] low_tgt, high_tgt;

    // bucket index of sample
    logic [4:0]  top;
    logic [8:0]  raw_idx;
    logic [BW-1:0] sidx;

    always_comb
    begin
        top = 5'd3;
        for (int i = 4; i < 32; i++)
            if (sample[i])
                top = 5'(i);
        raw_idx = 9'(sample[2:0]);
        if (sample[31:3] != 29'd0)
            raw_idx = 9'd8 + {1'b0, 5'(top - 5'd3), 3'd0}
                    + 9'((sample >> (top - 5'd3)) & 32'd7);
        if (raw_idx >= 9'(NUM_BUCKETS))
            sidx = LAST;
        else
            sidx = raw_idx[BW-1:0];
    end

    function automatic logic [31:0] edge_of(input logic [BW-1:0] idx);
        logic [8:0] j;
        logic [5:0] sh;
        logic [63:0] e;
        j = 9'(idx);
        if (j < 9'd8)
            edge_of = 32'(j);
        else
        begin
            sh = 6'((j - 9'd8) >> 3);
            if (sh > 6'd31)
                edge_of = 32'hFFFF_FFFF;
            else
            begin
                e = 64'(4'd8 + 4'((j - 9'd8) & 9'd7)) << sh;
                edge_of = e[31:0];
            end
        end
    endfunction

    // memory port
    logic          we;
    logic [BW-1:0] waddr;
    logic [31:0]   wdata;
    logic [BW-1:0] raddr;

    assign we    = cmd.add_write || clr_busy_reg;
    assign waddr = cmd.add_write ? sidx_reg : widx_reg;
    assign wdata = cmd.add_write ? rd_reg + 32'd1 : 32'd0;
    assign raddr = cmd.add_first ? sidx : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_first)
            sidx_reg <= sidx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            widx_reg      <= '0;
            walk_busy_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            ptr_reg       <= '0;
            min_reg       <= 32'hFFFF_FFFF;
            max_reg       <= 32'd0;
            cnt_reg       <= 32'd0;
            sum_reg       <= 64'd0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                clr_busy_reg <= 1'b1;
                widx_reg     <= '0;
                min_reg      <= 32'hFFFF_FFFF;
                max_reg      <= 32'd0;
                cnt_reg      <= 32'd0;
                sum_reg      <= 64'd0;
            end
            else if (clr_busy_reg)
            begin
                if (widx_reg == LAST)
                    clr_busy_reg <= 1'b0;
                else
                    widx_reg <= widx_reg + 1'b1;
            end
            if (cmd.add_first)
            begin
                if (sample < min_reg)
                    min_reg <= sample;
                if (sample > max_reg)
                    max_reg <= sample;
                cnt_reg <= cnt_reg + 32'd1;
                sum_reg <= sum_reg + 64'(sample);
            end
            if (cmd.walk_start)
            begin
                walk_busy_reg <= 1'b1;
                rd_valid_reg  <= 1'b0;
                ptr_reg       <= '0;
            end
            else if (cmd.walk_step && walk_busy_reg)
            begin
                rd_valid_reg <= 1'b1;
                if (ptr_reg != LAST)
                    ptr_reg <= ptr_reg + 1'b1;
                if (rd_valid_reg && wk_reg == LAST)
                    walk_busy_reg <= 1'b0;
            end
        end
    end

    // walk: rd_reg holds bucket at wk_reg (delayed pointer)
    logic [63:0]   low_acc, high_acc;
    assign low_acc  = low_seen_reg + 64'(rd_reg);
    assign high_acc = high_seen_reg + 64'(rd_reg);
    assign low_tgt  = low_q;
    assign high_tgt = high_q;

    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            wk_reg        <= '0;
            low_seen_reg  <= 64'd0;
            high_seen_reg <= 64'd0;
            low_hit_reg   <= 1'b0;
            high_hit_reg  <= 1'b0;
            low_edge_reg  <= max_reg;
            high_edge_reg <= max_reg;
        end
        else if (cmd.walk_step && rd_valid_reg && walk_busy_reg)
        begin
            wk_reg        <= wk_reg + 1'b1;
            low_seen_reg  <= low_acc;
            high_seen_reg <= high_acc;
            if (!low_hit_reg && low_acc >= low_tgt)
            begin
                low_hit_reg  <= 1'b1;
                low_edge_reg <= edge_of(wk_reg);
            end
            if (!high_hit_reg && high_acc >= high_tgt)
            begin
                high_hit_reg  <= 1'b1;
                high_edge_reg <= edge_of(wk_reg);
            end
        end
    end

    // report arithmetic: ceil(count*num/den) and sum/count
    always_ff @(posedge clk)
    begin
        if (cmd.rep_start)
        begin
            low_prod_reg  <= cnt_reg * low_num;
            high_prod_reg <= cnt_reg * high_num;
            lden_reg      <= (low_den == 16'd0) ? 16'd1 : low_den;
            hden_reg      <= (high_den == 16'd0) ? 16'd1 : high_den;
        end
    end

    logic div_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= cmd.rep_start;
    end

    lhp_divider u_div_low (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .step     (cmd.div_step),
        .dividend (64'(low_prod_reg) + 64'(lden_reg) - 64'd1),
        .divisor  (32'(lden_reg)),
        .quotient (low_q),
        .done     (low_done)
    );

    lhp_divider u_div_high (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .step     (cmd.div_step),
        .dividend (64'(high_prod_reg) + 64'(hden_reg) - 64'd1),
        .divisor  (32'(hden_reg)),
        .quotient (high_q),
        .done     (high_done)
    );

    lhp_divider u_div_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .step     (cmd.div_step),
        .dividend (sum_reg),
        .divisor  ((cnt_reg == 32'd0) ? 32'd1 : cnt_reg),
        .quotient (mean_q),
        .done     (mean_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cnt_reg == 32'd0)
            begin
                out_low_reg  <= 32'd0;
                out_high_reg <= 32'd0;
                out_min_reg  <= 32'd0;
                out_max_reg  <= 32'd0;
                out_mean_reg <= 32'd0;
                out_cnt_reg  <= 32'd0;
            end
            else
            begin
                out_low_reg  <= low_edge_reg;
                out_high_reg <= high_edge_reg;
                out_min_reg  <= min_reg;
                out_max_reg  <= max_reg;
                out_mean_reg <= mean_q[31:0];
                out_cnt_reg  <= cnt_reg;
            end
        end
    end

    assign sts.clr_done  = !clr_busy_reg;
    assign sts.div_done  = low_done && high_done && mean_done && !div_go_reg;
    assign sts.walk_done = rd_valid_reg && !walk_busy_reg;

    assign low_pct_edge  = out_low_reg;
    assign high_pct_edge = out_high_reg;
    assign min_seen      = out_min_reg;
    assign max_seen      = out_max_reg;
    assign mean_seen     = out_mean_reg;
    assign sample_count  = out_cnt_reg;
endmodule

// File: src/lhp_ctrl.sv
// ----------------------------------------------------------------------------
// lhp_ctrl: sequencer for add, clear and report transactions
// Issues datapath commands and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module lhp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    output logic              out_valid,
    input  logic              out_stall,
    output lhp_pkg::lhp_cmd_t cmd,
    input  lhp_pkg::lhp_sts_t sts
);
    import lhp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_CLEAR, S_DIV, S_WALK, S_LOAD, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE) || !sts.clr_done;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_ADD:
                        begin
                            cmd.add_first = 1'b1;
                            state_next    = S_ADD;
                        end
                        ACT_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        ACT_REPORT:
                        begin
                            cmd.rep_start = 1'b1;
                            state_next    = S_DIV;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_CLEAR:
            begin
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Latency histogram testbench
// Drives add, report, clear and unused-action transactions with random gaps
// and output stalls, predicts each report from a local model of the
// histogram and the percentile registers, and compares every field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lhp_pkg::*;

    localparam int unsigned NB = 168;

    typedef struct packed {
        logic [31:0] low_edge;
        logic [31:0] high_edge;
        logic [31:0] min_v;
        logic [31:0] max_v;
        logic [31:0] mean_v;
        logic [31:0] count_v;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = ACT_ADD;
    logic [31:0] sample = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] low_pct_edge, high_pct_edge, min_seen, max_seen, mean_seen, sample_count;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_LOW_NUM;
    logic [15:0] cfg_data = '0;

    latency_histogram_percentile #(.NUM_BUCKETS(NB)) u_top (.*);

    always #5 clk = ~clk;

    logic [31:0] hist [NB];
    logic [31:0] min_r, max_r, cnt_r;
    logic [63:0] sum_r;
    logic [15:0] pct_reg [4];
    report_t     pending_reports [$];
    int          mismatches = 0;
    int          reports_seen = 0;
    int          items_sent = 0;
    bit          stall_free = 1'b0;

    function automatic int unsigned bucket_index(logic [31:0] v);
        int unsigned top;
        int unsigned idx;
        if (v < 8) return v;
        top = 3;
        while (top < 31 && (v >> (top + 1)) != 0) top++;
        idx = 8 + (top - 3) * 8 + ((v >> (top - 3)) & 7);
        if (idx >= NB) idx = NB - 1;
        return idx;
    endfunction

    function automatic logic [31:0] edge_of(int unsigned idx);
        int unsigned sh;
        logic [63:0] e;
        if (idx < 8) return idx;
        sh = (idx - 8) / 8;
        if (sh > 31) return 32'hFFFF_FFFF;
        e = 64'(8 + (idx - 8) % 8) << sh;
        return e[31:0];
    endfunction

    function automatic logic [31:0] pct_edge(logic [15:0] num, logic [15:0] den);
        logic [63:0] tgt;
        logic [63:0] acc;
        logic [63:0] d;
        acc = 0;
        d = (den == 0) ? 64'd1 : 64'(den);
        tgt = (64'(cnt_r) * 64'(num) + d - 1) / d;
        for (int i = 0; i < NB; i++)
        begin
            acc += hist[i];
            if (acc >= tgt) return edge_of(i);
        end
        return max_r;
    endfunction

    function automatic void clear_hist();
        for (int i = 0; i < NB; i++) hist[i] = '0;
        min_r = '1;
        max_r = '0;
        cnt_r = '0;
        sum_r = '0;
    endfunction

    function automatic void predict(logic [1:0] act, logic [31:0] s);
        report_t r;
        int unsigned b;
        logic [63:0] q;
        if (act == ACT_ADD)
        begin
            if (s < min_r) min_r = s;
            if (s > max_r) max_r = s;
            sum_r += 64'(s);
            cnt_r++;
            b = bucket_index(s);
            hist[b]++;
        end
        else if (act == ACT_CLEAR)
            clear_hist();
        else if (act == ACT_REPORT)
        begin
            r = '0;
            if (cnt_r != 0)
            begin
                r.low_edge  = pct_edge(pct_reg[REG_LOW_NUM], pct_reg[REG_LOW_DEN]);
                r.high_edge = pct_edge(pct_reg[REG_HIGH_NUM], pct_reg[REG_HIGH_DEN]);
                r.min_v = min_r;
                r.max_v = max_r;
                q = sum_r / 64'(cnt_r);
                r.mean_v = q[31:0];
                r.count_v = cnt_r;
            end
            pending_reports.push_back(r);
        end
    endfunction

    task automatic send_item(logic [1:0] act, logic [31:0] s);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        sample <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict(act, s);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (NB + 120) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        pct_reg[idx] = v;
    endtask

    task automatic set_fractions(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                 logic [15:0] d);
        drain();
        write_reg(REG_LOW_NUM, a);
        write_reg(REG_LOW_DEN, b);
        write_reg(REG_HIGH_NUM, c);
        write_reg(REG_HIGH_DEN, d);
    endtask

    always @(negedge clk)
    begin
        if (stall_free) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 15) < 5);
    end

    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {low_pct_edge, high_pct_edge, min_seen, max_seen, mean_seen, sample_count};
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected report %h", got);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch exp %h got %h", want, got);
                end
            end
        end
    end

    function automatic logic [31:0] rand_sample();
        int unsigned sh;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return $urandom;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default:
            begin
                sh = $urandom_range(0, 31);
                return ($urandom >> sh);
            end
        endcase
    endfunction

    task automatic test_directed();
        send_item(ACT_REPORT, 0);
        send_item(ACT_ADD, 0);
        send_item(ACT_ADD, 7);
        send_item(ACT_ADD, 8);
        send_item(ACT_ADD, 32'hFFFF_FFFF);
        send_item(ACT_ADD, 32'h8000_0000);
        send_item(ACT_ADD, 32'h5555_5555);
        send_item(ACT_ADD, 32'hAAAA_AAAA);
        send_item(2'd3, 32'h1234_5678);
        send_item(ACT_REPORT, 0);
        send_item(ACT_CLEAR, 0);
        send_item(ACT_REPORT, 0);
        send_item(ACT_ADD, 15);
        send_item(ACT_ADD, 16);
        send_item(ACT_REPORT, 0);
    endtask

    task automatic test_fraction_edges();
        set_fractions(0, 0, 16'hFFFF, 1);
        send_item(ACT_ADD, 100);
        send_item(ACT_ADD, 3);
        send_item(ACT_REPORT, 0);
        set_fractions(16'hFFFF, 16'hFFFF, 1, 16'hFFFF);
        send_item(ACT_REPORT, 0);
        set_fractions(1, 2, 99, 100);
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            if (i % 200 == 100)
                set_fractions(16'($urandom), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 200)), 16'($urandom_range(1, 200)));
            stall_free = (i % 250) >= 220;
            r = $urandom_range(0, 99);
            if (r < 75) send_item(ACT_ADD, rand_sample());
            else if (r < 93) send_item(ACT_REPORT, $urandom);
            else if (r < 97) send_item(ACT_CLEAR, $urandom);
            else send_item(2'd3, $urandom);
        end
        stall_free = 1'b0;
    endtask

    initial
    begin
        pct_reg[REG_LOW_NUM] = 1;
        pct_reg[REG_LOW_DEN] = 2;
        pct_reg[REG_HIGH_NUM] = 99;
        pct_reg[REG_HIGH_DEN] = 100;
        clear_hist();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_fraction_edges();
        test_random(800);
        drain();
        $display("sent %0d transactions, checked %0d reports across several fraction settings",
                 items_sent, reports_seen);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
